// ===== rtl/core/su2lp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// su2lp_pkg
// Widths, selector bit positions and component indexes for the SU(2) link
// product core.
// ----------------------------------------------------------------------------
package su2lp_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned COMP_W = 32;
  localparam int unsigned FRAC_W = 30;
  localparam int unsigned NCOMP  = 4;
  localparam int unsigned NTERM  = 4;

  localparam int unsigned PROD_W = 2 * COMP_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned QUO_W  = SUM_W - FRAC_W;

  // selector bits
  localparam int unsigned OP_CONJ_B = 0;
  localparam int unsigned OP_CONJ_A = 1;

  // component indexes
  localparam int unsigned CX = 0;
  localparam int unsigned CY = 1;
  localparam int unsigned CZ = 2;
  localparam int unsigned CW = 3;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [QUO_W-1:0]  quo_t;

  localparam sum_t ROUND_HALF = sum_t'(1) <<< (FRAC_W - 1);
  localparam quo_t SAT_MAX    = quo_t'({1'b0, {(COMP_W-1){1'b1}}});
  localparam quo_t SAT_MIN    = -SAT_MAX - quo_t'(1);

  function automatic pair_t signed_term(input prod_t p, input logic neg);
    pair_t w;
    w = pair_t'(p);
    return neg ? -w : w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/su2_link_product_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// su2_link_product_core
// Product of two SU(2) elements held as Q2.30 quaternions, with optional
// conjugation of either operand, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
// The core takes one item per cycle while in_stall is low and returns one
// result per item, in order, from the stage five register. Stage one
// registers the operands, stage two holds the sixteen 32x32 signed products,
// stage three adds them in pairs with their signs, stage four forms the full
// sum plus the rounding half, and stage five shifts and saturates into the
// output register. Each stage holds its item while the stage after it is
// full and stalled, so bubbles close up and in_stall rises only when all
// five stages are full and out_stall is high.
module su2_link_product_core
  import su2lp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          op,
  input  wire logic signed [COMP_W-1:0] a_x,
  input  wire logic signed [COMP_W-1:0] a_y,
  input  wire logic signed [COMP_W-1:0] a_z,
  input  wire logic signed [COMP_W-1:0] a_w,
  input  wire logic signed [COMP_W-1:0] b_x,
  input  wire logic signed [COMP_W-1:0] b_y,
  input  wire logic signed [COMP_W-1:0] b_z,
  input  wire logic signed [COMP_W-1:0] b_w,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [COMP_W-1:0]      prod_x,
  output logic signed [COMP_W-1:0]      prod_y,
  output logic signed [COMP_W-1:0]      prod_z,
  output logic signed [COMP_W-1:0]      prod_w
);

  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  logic [OP_W-1:0] op1;
  comp_t           a1 [NCOMP];
  comp_t           b1 [NCOMP];

  prod_t p2   [NCOMP][NTERM];
  logic  neg2 [NCOMP][NTERM];

  pair_t s3 [NCOMP][2];
  sum_t  s4 [NCOMP];
  comp_t r5 [NCOMP];

  logic ca, cb, cx;
  prod_t p2_next   [NCOMP][NTERM];
  logic  neg2_next [NCOMP][NTERM];
  quo_t  q4 [NCOMP];

  assign adv5 = !v5 || !out_stall;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // stage 1: operand capture
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      op1    <= op;
      a1[CX] <= a_x;
      a1[CY] <= a_y;
      a1[CZ] <= a_z;
      a1[CW] <= a_w;
      b1[CX] <= b_x;
      b1[CY] <= b_y;
      b1[CZ] <= b_z;
      b1[CW] <= b_w;
    end
  end

  // stage 2: products and their signs
  always_comb begin
    cb = op1[OP_CONJ_B];
    ca = op1[OP_CONJ_A];
    cx = ca ^ cb;

    p2_next[CX][0] = a1[CW] * b1[CX];  neg2_next[CX][0] = cb;
    p2_next[CX][1] = a1[CX] * b1[CW];  neg2_next[CX][1] = ca;
    p2_next[CX][2] = a1[CY] * b1[CZ];  neg2_next[CX][2] = !cx;
    p2_next[CX][3] = a1[CZ] * b1[CY];  neg2_next[CX][3] = cx;

    p2_next[CY][0] = a1[CW] * b1[CY];  neg2_next[CY][0] = cb;
    p2_next[CY][1] = a1[CY] * b1[CW];  neg2_next[CY][1] = ca;
    p2_next[CY][2] = a1[CX] * b1[CZ];  neg2_next[CY][2] = cx;
    p2_next[CY][3] = a1[CZ] * b1[CX];  neg2_next[CY][3] = !cx;

    p2_next[CZ][0] = a1[CW] * b1[CZ];  neg2_next[CZ][0] = cb;
    p2_next[CZ][1] = a1[CZ] * b1[CW];  neg2_next[CZ][1] = ca;
    p2_next[CZ][2] = a1[CX] * b1[CY];  neg2_next[CZ][2] = !cx;
    p2_next[CZ][3] = a1[CY] * b1[CX];  neg2_next[CZ][3] = cx;

    p2_next[CW][0] = a1[CW] * b1[CW];  neg2_next[CW][0] = 1'b0;
    p2_next[CW][1] = a1[CX] * b1[CX];  neg2_next[CW][1] = !cx;
    p2_next[CW][2] = a1[CY] * b1[CY];  neg2_next[CW][2] = !cx;
    p2_next[CW][3] = a1[CZ] * b1[CZ];  neg2_next[CW][3] = !cx;
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      p2   <= p2_next;
      neg2 <= neg2_next;
    end
  end

  // stage 3: signed pair sums
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      for (int c = 0; c < NCOMP; c++) begin
        s3[c][0] <= signed_term(p2[c][0], neg2[c][0]) + signed_term(p2[c][1], neg2[c][1]);
        s3[c][1] <= signed_term(p2[c][2], neg2[c][2]) + signed_term(p2[c][3], neg2[c][3]);
      end
    end
  end

  // stage 4: full sum plus rounding half
  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      for (int c = 0; c < NCOMP; c++) begin
        s4[c] <= sum_t'(s3[c][0]) + sum_t'(s3[c][1]) + ROUND_HALF;
      end
    end
  end

  // stage 5: drop fraction and saturate
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      q4[c] = quo_t'(s4[c] >>> FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv5 && v4) begin
      for (int c = 0; c < NCOMP; c++) begin
        priority if (q4[c] > SAT_MAX) begin
          r5[c] <= comp_t'(SAT_MAX);
        end else if (q4[c] < SAT_MIN) begin
          r5[c] <= comp_t'(SAT_MIN);
        end else begin
          r5[c] <= comp_t'(q4[c]);
        end
      end
    end
  end

  assign out_valid = v5;
  assign prod_x    = r5[CX];
  assign prod_y    = r5[CY];
  assign prod_z    = r5[CZ];
  assign prod_w    = r5[CW];

endmodule
`default_nettype wire
